// ===== hdl/mlsd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MAC learning switch decision package
// Request types, action codes and fixed addresses shared by the bridge logic.
// ----------------------------------------------------------------------------
package mlsd_pkg;

  localparam int unsigned MacWidth  = 48;
  localparam int unsigned PortWidth = 32;
  localparam int unsigned BufWidth  = 32;
  localparam int unsigned GroupBit  = 40;

  localparam logic [MacWidth-1:0]  ReservedDst = 48'h0180_C200_0000;
  localparam logic [BufWidth-1:0]  NoBuffer    = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ActIgnore  = 3'd0,
    ActDrop    = 3'd1,
    ActFlood   = 3'd2,
    ActForward = 3'd3,
    ActInstall = 3'd4
  } action_e;

  typedef struct packed {
    logic [MacWidth-1:0]  src_mac;
    logic [MacWidth-1:0]  dst_mac;
    logic [PortWidth-1:0] ingress_port;
    logic [BufWidth-1:0]  buffer_ref;
  } in_req_t;

  typedef struct packed {
    action_e              action;
    logic [PortWidth-1:0] out_port;
    logic                 install_flow;
    logic [BufWidth-1:0]  buffer_echo;
    logic                 source_learned;
  } out_req_t;

endpackage
`default_nettype wire

// ===== hdl/mlsd_cam.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MAC address table
// Flop-based key store with parallel source and destination compares, slot
// choice for learning and round-robin replacement once the table is full.
// ----------------------------------------------------------------------------
module mlsd_cam
  import mlsd_pkg::*;
#(
  parameter int unsigned Entries = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [MacWidth-1:0]          src_mac_i,
  input  wire logic [MacWidth-1:0]          dst_mac_i,
  input  wire logic                         learn_req_i,
  input  wire logic                         learn_we_i,
  output logic [$clog2(Entries)-1:0]        learn_idx_o,
  output logic                              dst_hit_o,
  output logic                              dst_fwd_o,
  output logic [$clog2(Entries)-1:0]        dst_idx_o
);

  localparam int unsigned IdxWidth  = $clog2(Entries);
  localparam int unsigned FillWidth = $clog2(Entries + 1);

  logic [MacWidth-1:0]  keys_q [Entries];
  logic [Entries-1:0]   valid_q;
  logic [FillWidth-1:0] fill_q;
  logic [IdxWidth-1:0]  rptr_q;

  logic [Entries-1:0]   src_vec;
  logic [Entries-1:0]   dst_vec;
  logic [Entries-1:0]   wr_vec;
  logic [Entries-1:0]   dst_eff;
  logic                 src_hit;
  logic                 full;
  logic [IdxWidth-1:0]  src_idx;
  logic [IdxWidth-1:0]  dst_enc;

  always_comb begin
    src_idx = '0;
    dst_enc = '0;
    for (int unsigned i = 0; i < Entries; i++) begin
      src_vec[i] = valid_q[i] && (keys_q[i] == src_mac_i);
      dst_vec[i] = valid_q[i] && (keys_q[i] == dst_mac_i);
    end
    src_hit = |src_vec;
    full    = (fill_q == FillWidth'(Entries));
    for (int unsigned i = 0; i < Entries; i++) begin
      if (src_vec[i]) begin
        src_idx = src_idx | IdxWidth'(i);
      end
    end
    if (src_hit) begin
      learn_idx_o = src_idx;
    end else if (!full) begin
      learn_idx_o = fill_q[IdxWidth-1:0];
    end else begin
      learn_idx_o = rptr_q;
    end
    for (int unsigned i = 0; i < Entries; i++) begin
      wr_vec[i] = learn_req_i && (learn_idx_o == IdxWidth'(i));
    end
    // An entry being overwritten this cycle no longer holds its old key.
    dst_eff = dst_vec & ~wr_vec;
    for (int unsigned i = 0; i < Entries; i++) begin
      if (dst_eff[i]) begin
        dst_enc = dst_enc | IdxWidth'(i);
      end
    end
    dst_fwd_o = learn_req_i && (dst_mac_i == src_mac_i);
    dst_hit_o = dst_fwd_o || (|dst_eff);
    dst_idx_o = dst_fwd_o ? learn_idx_o : dst_enc;
  end

  always_ff @(posedge clk_i) begin
    if (learn_we_i) begin
      keys_q[learn_idx_o] <= src_mac_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fill_q  <= '0;
      rptr_q  <= '0;
    end else if (learn_we_i) begin
      valid_q[learn_idx_o] <= 1'b1;
      if (!src_hit && !full) begin
        fill_q <= fill_q + FillWidth'(1);
      end
      if (!src_hit && full) begin
        if (rptr_q == IdxWidth'(Entries - 1)) begin
          rptr_q <= '0;
        end else begin
          rptr_q <= rptr_q + IdxWidth'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mlsd_port_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Learned port memory
// One write port and one registered read port holding the port of each entry.
// ----------------------------------------------------------------------------
module mlsd_port_ram
  import mlsd_pkg::*;
#(
  parameter int unsigned Entries = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [$clog2(Entries)-1:0]  waddr_i,
  input  wire logic [PortWidth-1:0]        wdata_i,
  input  wire logic                        re_i,
  input  wire logic [$clog2(Entries)-1:0]  raddr_i,
  output logic [PortWidth-1:0]             rdata_o
);

  logic [PortWidth-1:0] mem [Entries];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mac_learning_switch_decision.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MAC learning switch decision
// Ethernet learning bridge: learns frame sources and chooses the action for
// each frame header.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the input channel carries one frame header (source and
// destination MAC, ingress port, buffer reference). For every input request
// exactly one result request leaves on the output channel, in order.
// Both channels use a valid/ready handshake.
// From input acceptance a request passes two registers: the input register,
// where the table compare, learning and action choice take place, and the
// result register, which also holds the port memory read data.
// Throughput is one request per cycle while the receiver does not stall, set by
// the single pass through the parallel key compare of the address table.
// When the receiver stalls, the result register holds its request and the
// input register can still take one more; input ready falls once both are
// full. Reset clears the table valid marks, fill count and replacement
// pointer, so no address is known after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module mac_learning_switch_decision
  import mlsd_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_req_t  in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_req_t      out_req_o
);

  localparam int unsigned IdxWidth = $clog2(TABLE_ENTRIES);

  in_req_t              s1_q;
  logic                 s1_valid_q;
  logic                 s2_valid_q;
  action_e              action_q, action_d;
  logic                 install_q, install_d;
  logic [BufWidth-1:0]  echo_q, echo_d;
  logic                 learned_q, learned_d;
  logic                 use_ram_q, use_ram_d;
  logic [PortWidth-1:0] port_q, port_d;

  logic                 s2_adv;
  logic                 unicast;
  logic                 learn_req;
  logic                 learn_we;
  logic [IdxWidth-1:0]  learn_idx;
  logic                 dst_hit;
  logic                 dst_fwd;
  logic [IdxWidth-1:0]  dst_idx;
  logic [PortWidth-1:0] ram_rdata;

  assign s2_adv     = !s2_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s2_adv;
  assign unicast    = !s1_q.src_mac[GroupBit];
  assign learn_req  = s1_valid_q && unicast;
  assign learn_we   = learn_req && s2_adv;

  mlsd_cam #(
    .Entries(TABLE_ENTRIES)
  ) u_cam (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .src_mac_i  (s1_q.src_mac),
    .dst_mac_i  (s1_q.dst_mac),
    .learn_req_i(learn_req),
    .learn_we_i (learn_we),
    .learn_idx_o(learn_idx),
    .dst_hit_o  (dst_hit),
    .dst_fwd_o  (dst_fwd),
    .dst_idx_o  (dst_idx)
  );

  mlsd_port_ram #(
    .Entries(TABLE_ENTRIES)
  ) u_port_ram (
    .clk_i  (clk_i),
    .we_i   (learn_we),
    .waddr_i(learn_idx),
    .wdata_i(s1_q.ingress_port),
    .re_i   (s1_valid_q && s2_adv),
    .raddr_i(dst_idx),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    action_d  = ActIgnore;
    install_d = 1'b0;
    echo_d    = '0;
    learned_d = 1'b0;
    use_ram_d = 1'b0;
    port_d    = '0;
    if (unicast) begin
      learned_d = 1'b1;
      echo_d    = s1_q.buffer_ref;
      if (s1_q.dst_mac == ReservedDst) begin
        action_d = ActDrop;
      end else if (s1_q.dst_mac[GroupBit] || !dst_hit) begin
        action_d = ActFlood;
      end else begin
        install_d = 1'b1;
        action_d  = (s1_q.buffer_ref != NoBuffer) ? ActForward : ActInstall;
        if (dst_fwd) begin
          port_d = s1_q.ingress_port;
        end else begin
          use_ram_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_req_i;
    end
    if (s2_adv && s1_valid_q) begin
      action_q  <= action_d;
      install_q <= install_d;
      echo_q    <= echo_d;
      learned_q <= learned_d;
      use_ram_q <= use_ram_d;
      port_q    <= port_d;
    end
  end

  assign out_valid_o              = s2_valid_q;
  assign out_req_o.action         = action_q;
  assign out_req_o.out_port       = use_ram_q ? ram_rdata : port_q;
  assign out_req_o.install_flow   = install_q;
  assign out_req_o.buffer_echo    = echo_q;
  assign out_req_o.source_learned = learned_q;

  a_install_needs_learn : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.install_flow |-> out_req_o.source_learned)
    else $error("Flow installed for a request whose source was not learned.");

  a_stage_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_adv |=> s1_valid_q && $stable(s1_q))
    else $error("Input register changed while the result register was stalled.");

  a_self_dest : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_adv && unicast && (s1_q.dst_mac == s1_q.src_mac)
      && (s1_q.dst_mac != ReservedDst)
    |=> out_valid_o && out_req_o.install_flow
      && (out_req_o.out_port == $past(s1_q.ingress_port)))
    else $error("Frame to its own source was not sent back to the ingress port.");

endmodule
`default_nettype wire
